// ===== hw/rtl/bgmc_pkg.sv =====
// Package for the Bayer gain-map correction block.
// Holds sizes, register indexes, command codes and the structs passed between stages.
// Depends on nothing; every other file of the block imports it.
package bgmc_pkg;

    // Sizes of the gain maps and the pixel path.
    localparam int GRID_DIM    = 64;
    localparam int NUM_MAPS    = 4;
    localparam int PIXEL_BITS  = 16;
    localparam int MAP_ENTRIES = 4096;
    localparam int ENTRY_W     = 12;
    localparam int MAP_W       = 2;
    localparam int ADDR_W      = MAP_W + ENTRY_W;
    localparam int RAM_DEPTH   = 1 << ADDR_W;
    localparam int GAIN_W      = 16;
    localparam int STEP_W      = 24;
    localparam int COORD_W     = 16;
    localparam int POS_W       = COORD_W + STEP_W;
    localparam int FRAC_W      = 12;
    localparam int IDX_W       = $clog2(GRID_DIM);
    localparam int GC_W        = 7;
    localparam int BLK_W       = 16;
    localparam int DIFF_W      = BLK_W + 1;
    localparam int HB_W        = GAIN_W + FRAC_W;
    localparam int GQ_W        = GAIN_W + 2 * FRAC_W;
    localparam int GQ_HALF     = GQ_W / 2;
    localparam int PP_W        = DIFF_W + GQ_HALF + 1;
    localparam int TOT_W       = 60;
    localparam int RND_POS     = 3 * FRAC_W - 1;
    localparam int RES_W       = TOT_W - RND_POS - 1;

    // The row count is min(GRID_DIM, MAP_ENTRIES / cols); with GRID_DIM squared not
    // above MAP_ENTRIES it is always GRID_DIM.
    localparam int GRID_ROWS   = GRID_DIM;

    // Configuration port.
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_BLACK0    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLACK1    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLACK2    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLACK3    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_STEP  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_STEP  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_MAP = 3'd7;

    localparam logic [GC_W-1:0] GRID_COLS_RST = 7'd2;
    localparam logic [7:0]      PHASE_MAP_RST = 8'd228;

    // Commands.
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Item fields that ride along the pipeline.
    typedef struct packed {
        logic                     cmd;
        logic [MAP_W-1:0]         map;
        logic                     wr_ok;
        logic [ENTRY_W-1:0]       entry;
        logic [GAIN_W-1:0]        gain;
        logic signed [DIFF_W-1:0] diff;
        logic [BLK_W-1:0]         blk;
    } t_item;

    // Grid corners and weights of one pixel.
    typedef struct packed {
        logic [IDX_W-1:0]  x0;
        logic [IDX_W-1:0]  x1;
        logic [IDX_W-1:0]  y0;
        logic [IDX_W-1:0]  y1;
        logic [FRAC_W-1:0] fx;
        logic [FRAC_W-1:0] fy;
    } t_loc;

    // What the back end needs after the gain lookup.
    typedef struct packed {
        logic                     cmd;
        logic signed [DIFF_W-1:0] diff;
        logic [BLK_W-1:0]         blk;
    } t_tail;

    // Wraps a phase-selected map number into the range of existing maps.
    function automatic logic [MAP_W-1:0] map_wrap(input logic [MAP_W-1:0] sel);
        logic [MAP_W-1:0] res;
        res = sel;
        if (NUM_MAPS == 1) begin
            res = '0;
        end else if (32'(sel) >= NUM_MAPS) begin
            res = MAP_W'(32'(sel) - NUM_MAPS);
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/bgmc_ifs.sv =====
// Channel interfaces of the Bayer gain-map correction block.
// Pixel/write commands in, corrected pixels out, and the register write channel.
// Depends on bgmc_pkg.
interface bgmc_pix_if;
    import bgmc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic                  command;
    logic [COORD_W-1:0]    pixel_row;
    logic [COORD_W-1:0]    pixel_col;
    logic [PIXEL_BITS-1:0] pixel_value;
    logic [1:0]            cfa_color;
    logic [MAP_W-1:0]      map_select;
    logic [ENTRY_W-1:0]    entry_index;
    logic [GAIN_W-1:0]     gain_value;
    modport src (output valid, command, pixel_row, pixel_col, pixel_value, cfa_color,
                 map_select, entry_index, gain_value, input ready);
    modport snk (input valid, command, pixel_row, pixel_col, pixel_value, cfa_color,
                 map_select, entry_index, gain_value, output ready);
endinterface

interface bgmc_res_if;
    import bgmc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] corrected_value;
    modport src (output valid, corrected_value, input ready);
    modport snk (input valid, corrected_value, output ready);
endinterface

interface bgmc_cfg_if;
    import bgmc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport src (output valid, index, data, input ready);
    modport snk (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/bayer_gain_map_correction.sv =====
// Top level of the Bayer gain-map correction block: registers, gain storage and
// the pipeline from command to corrected pixel.
// Depends on bgmc_pkg, bgmc_ifs, bgmc_pos, bgmc_gain_ram, bgmc_interp, bgmc_apply.
//
//  Channel  Dir  Carries
//  i_pix    in   pixel correction or gain write command
//  o_res    out  corrected pixel, one per pixel command
//  i_cfg    in   register writes, index 0..7, always ready
//
// One command enters per cycle when not stalled; a pixel passes stages A to G and
// the output register. The rate is set by the two dual-read gain memories, which
// serve all four corners together; writes take the same path so ordering is kept.
// Reset clears valid bits and presets registers; the gain storage is not cleared.
// A stalled output freezes the whole pipeline together with the input ready.
module bayer_gain_map_correction (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bgmc_pix_if.snk      i_pix,
    bgmc_res_if.src      o_res,
    bgmc_cfg_if.snk      i_cfg
);
    import bgmc_pkg::*;

    logic [BLK_W-1:0]      r_black [4];
    logic [STEP_W-1:0]     r_col_step;
    logic [STEP_W-1:0]     r_row_step;
    logic [GC_W-1:0]       r_grid_cols;
    logic [7:0]            r_phase_map;
    logic [GC_W-1:0]       gc;
    logic                  en;
    logic                  out_valid;
    t_item                 in_item;
    logic [1:0]            phase;
    logic [BLK_W-1:0]      blk;
    logic                  b_valid;
    t_item                 b_item;
    t_loc                  b_loc;
    logic [ENTRY_W-1:0]    e00;
    logic [ENTRY_W-1:0]    e01;
    logic [ENTRY_W-1:0]    e10;
    logic [ENTRY_W-1:0]    e11;
    logic [ENTRY_W-1:0]    row0;
    logic [ENTRY_W-1:0]    row1;
    logic                  we;
    logic                  r_c_valid;
    t_tail                 r_c_tail;
    logic [FRAC_W-1:0]     r_c_fx;
    logic [FRAC_W-1:0]     r_c_fy;
    logic [GAIN_W-1:0]     g00;
    logic [GAIN_W-1:0]     g01;
    logic [GAIN_W-1:0]     g10;
    logic [GAIN_W-1:0]     g11;
    logic                  e_valid;
    t_tail                 e_tail;
    logic [GQ_W-1:0]       e_gq;

    // Configuration registers.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_black[0]  <= '0;
            r_black[1]  <= '0;
            r_black[2]  <= '0;
            r_black[3]  <= '0;
            r_col_step  <= '0;
            r_row_step  <= '0;
            r_grid_cols <= GRID_COLS_RST;
            r_phase_map <= PHASE_MAP_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_BLACK0:    r_black[0]  <= i_cfg.data[BLK_W-1:0];
                CFG_BLACK1:    r_black[1]  <= i_cfg.data[BLK_W-1:0];
                CFG_BLACK2:    r_black[2]  <= i_cfg.data[BLK_W-1:0];
                CFG_BLACK3:    r_black[3]  <= i_cfg.data[BLK_W-1:0];
                CFG_COL_STEP:  r_col_step  <= i_cfg.data[STEP_W-1:0];
                CFG_ROW_STEP:  r_row_step  <= i_cfg.data[STEP_W-1:0];
                CFG_GRID_COLS: r_grid_cols <= i_cfg.data[GC_W-1:0];
                CFG_PHASE_MAP: r_phase_map <= i_cfg.data[7:0];
                default:       r_phase_map <= r_phase_map;
            endcase
        end
    end

    // Grid columns clamped to the supported range.
    always_comb begin
        if (r_grid_cols < GC_W'(2)) begin
            gc = GC_W'(2);
        end else if (32'(r_grid_cols) > GRID_DIM) begin
            gc = GC_W'(GRID_DIM);
        end else begin
            gc = r_grid_cols;
        end
    end

    // The pipeline moves whenever the output register is free or being taken.
    assign en          = !out_valid || o_res.ready;
    assign i_pix.ready = en;

    // Command decode: map choice, black level and difference.
    assign phase = {i_pix.pixel_row[0], i_pix.pixel_col[0]};
    assign blk   = r_black[i_pix.cfa_color];

    always_comb begin
        in_item.cmd   = i_pix.command;
        in_item.wr_ok = (32'(i_pix.map_select) < NUM_MAPS);
        if (i_pix.command == CMD_WRITE) begin
            in_item.map = i_pix.map_select;
        end else begin
            in_item.map = map_wrap(r_phase_map[2*phase +: 2]);
        end
        in_item.entry = i_pix.entry_index;
        in_item.gain  = i_pix.gain_value;
        in_item.blk   = blk;
        in_item.diff  = $signed({1'b0, i_pix.pixel_value}) - $signed({1'b0, blk});
    end

    bgmc_pos u_pos (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (i_pix.valid),
        .i_item     (in_item),
        .i_row      (i_pix.pixel_row),
        .i_col      (i_pix.pixel_col),
        .i_col_step (r_col_step),
        .i_row_step (r_row_step),
        .i_gc       (gc),
        .o_valid    (b_valid),
        .o_item     (b_item),
        .o_loc      (b_loc)
    );

    // Stage C: corner addresses, gain write and lookup.
    assign row0 = ENTRY_W'(b_loc.y0 * gc);
    assign row1 = ENTRY_W'(b_loc.y1 * gc);
    assign e00  = row0 + ENTRY_W'(b_loc.x0);
    assign e01  = row0 + ENTRY_W'(b_loc.x1);
    assign e10  = row1 + ENTRY_W'(b_loc.x0);
    assign e11  = row1 + ENTRY_W'(b_loc.x1);
    assign we   = en && b_valid && (b_item.cmd == CMD_WRITE) && b_item.wr_ok;

    bgmc_gain_ram u_ram_top (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_we      (we),
        .i_waddr   ({b_item.map, b_item.entry}),
        .i_wdata   (b_item.gain),
        .i_raddr_a ({b_item.map, e00}),
        .i_raddr_b ({b_item.map, e01}),
        .o_rdata_a (g00),
        .o_rdata_b (g01)
    );

    bgmc_gain_ram u_ram_bot (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_we      (we),
        .i_waddr   ({b_item.map, b_item.entry}),
        .i_wdata   (b_item.gain),
        .i_raddr_a ({b_item.map, e10}),
        .i_raddr_b ({b_item.map, e11}),
        .o_rdata_a (g10),
        .o_rdata_b (g11)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (en) begin
            r_c_valid <= b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_tail.cmd  <= b_item.cmd;
            r_c_tail.diff <= b_item.diff;
            r_c_tail.blk  <= b_item.blk;
            r_c_fx        <= b_loc.fx;
            r_c_fy        <= b_loc.fy;
        end
    end

    bgmc_interp u_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_c_valid),
        .i_tail  (r_c_tail),
        .i_fx    (r_c_fx),
        .i_fy    (r_c_fy),
        .i_g00   (g00),
        .i_g01   (g01),
        .i_g10   (g10),
        .i_g11   (g11),
        .o_valid (e_valid),
        .o_tail  (e_tail),
        .o_gq    (e_gq)
    );

    bgmc_apply u_apply (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (e_valid),
        .i_tail  (e_tail),
        .i_gq    (e_gq),
        .o_valid (out_valid),
        .o_value (o_res.corrected_value)
    );

    assign o_res.valid = out_valid;

    // A gain write only happens for a valid write command on a moving pipeline.
    a_we_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> (b_valid && b_item.cmd == CMD_WRITE && en))
        else $error("gain write without a write command");

    // Input is refused exactly when a finished pixel is held at the output.
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pix.ready |-> (out_valid && !o_res.ready))
        else $error("input refused without a stall");

    // Corner addresses stay inside one map.
    a_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (b_valid && b_item.cmd == CMD_PIXEL) |->
            ((32'(b_loc.y1) * 32'(gc) + 32'(b_loc.x1)) < MAP_ENTRIES))
        else $error("corner address out of map");
endmodule

// ===== hw/rtl/bgmc_gain_ram.sv =====
// Gain storage: one write port and two registered read ports.
// Two copies of it give the four corner reads of each pixel.
// Depends on bgmc_pkg.
module bgmc_gain_ram (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic                          i_we,
    input  logic [bgmc_pkg::ADDR_W-1:0]   i_waddr,
    input  logic [bgmc_pkg::GAIN_W-1:0]   i_wdata,
    input  logic [bgmc_pkg::ADDR_W-1:0]   i_raddr_a,
    input  logic [bgmc_pkg::ADDR_W-1:0]   i_raddr_b,
    output logic [bgmc_pkg::GAIN_W-1:0]   o_rdata_a,
    output logic [bgmc_pkg::GAIN_W-1:0]   o_rdata_b
);
    import bgmc_pkg::*;

    logic [GAIN_W-1:0] r_mem [RAM_DEPTH];
    logic [GAIN_W-1:0] r_rdata_a;
    logic [GAIN_W-1:0] r_rdata_b;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read ports, held while the pipeline stalls.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;
endmodule

// ===== hw/rtl/bgmc_pos.sv =====
// Grid placement: scales the pixel coordinates by the step registers, then finds
// the corner indexes and 12-bit weights. Two register stages. Depends on bgmc_pkg.
module bgmc_pos (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  bgmc_pkg::t_item               i_item,
    input  logic [bgmc_pkg::COORD_W-1:0]  i_row,
    input  logic [bgmc_pkg::COORD_W-1:0]  i_col,
    input  logic [bgmc_pkg::STEP_W-1:0]   i_col_step,
    input  logic [bgmc_pkg::STEP_W-1:0]   i_row_step,
    input  logic [bgmc_pkg::GC_W-1:0]     i_gc,
    output logic                          o_valid,
    output bgmc_pkg::t_item               o_item,
    output bgmc_pkg::t_loc                o_loc
);
    import bgmc_pkg::*;

    localparam logic [GC_W-1:0] ROW_LAST = GC_W'(GRID_ROWS - 1);

    logic             r_a_valid;
    t_item            r_a_item;
    logic [POS_W-1:0] r_a_posx;
    logic [POS_W-1:0] r_a_posy;
    logic             r_b_valid;
    t_item            r_b_item;
    t_loc             r_b_loc;
    t_loc             n_b_loc;
    logic [GC_W-1:0]  col_last;

    // Stage A: coordinate times step, Q16.24.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_item <= i_item;
            r_a_posx <= POS_W'(i_col) * POS_W'(i_col_step);
            r_a_posy <= POS_W'(i_row) * POS_W'(i_row_step);
        end
    end

    // Stage B: clamp past the last grid point with weight zero.
    assign col_last = i_gc - GC_W'(1);

    always_comb begin
        if (r_a_posx[POS_W-1:STEP_W] >= COORD_W'(col_last)) begin
            n_b_loc.x0 = col_last[IDX_W-1:0];
            n_b_loc.x1 = col_last[IDX_W-1:0];
            n_b_loc.fx = '0;
        end else begin
            n_b_loc.x0 = r_a_posx[STEP_W +: IDX_W];
            n_b_loc.x1 = r_a_posx[STEP_W +: IDX_W] + IDX_W'(1);
            n_b_loc.fx = r_a_posx[STEP_W-1 -: FRAC_W];
        end
        if (r_a_posy[POS_W-1:STEP_W] >= COORD_W'(ROW_LAST)) begin
            n_b_loc.y0 = ROW_LAST[IDX_W-1:0];
            n_b_loc.y1 = ROW_LAST[IDX_W-1:0];
            n_b_loc.fy = '0;
        end else begin
            n_b_loc.y0 = r_a_posy[STEP_W +: IDX_W];
            n_b_loc.y1 = r_a_posy[STEP_W +: IDX_W] + IDX_W'(1);
            n_b_loc.fy = r_a_posy[STEP_W-1 -: FRAC_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (i_en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_item <= r_a_item;
            r_b_loc  <= n_b_loc;
        end
    end

    assign o_valid = r_b_valid;
    assign o_item  = r_b_item;
    assign o_loc   = r_b_loc;
endmodule

// ===== hw/rtl/bgmc_interp.sv =====
// Bilinear blend of the four corner gains: horizontal in one stage (Q4.24),
// vertical in the next (Q4.36). Depends on bgmc_pkg.
module bgmc_interp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  bgmc_pkg::t_tail               i_tail,
    input  logic [bgmc_pkg::FRAC_W-1:0]   i_fx,
    input  logic [bgmc_pkg::FRAC_W-1:0]   i_fy,
    input  logic [bgmc_pkg::GAIN_W-1:0]   i_g00,
    input  logic [bgmc_pkg::GAIN_W-1:0]   i_g01,
    input  logic [bgmc_pkg::GAIN_W-1:0]   i_g10,
    input  logic [bgmc_pkg::GAIN_W-1:0]   i_g11,
    output logic                          o_valid,
    output bgmc_pkg::t_tail               o_tail,
    output logic [bgmc_pkg::GQ_W-1:0]     o_gq
);
    import bgmc_pkg::*;

    localparam logic [FRAC_W:0] W_ONE = (FRAC_W+1)'(1 << FRAC_W);

    logic              r_d_valid;
    t_tail             r_d_tail;
    logic [FRAC_W-1:0] r_d_fy;
    logic [HB_W-1:0]   r_d_b;
    logic [HB_W-1:0]   r_d_t;
    logic              r_e_valid;
    t_tail             r_e_tail;
    logic [GQ_W-1:0]   r_e_gq;
    logic [FRAC_W:0]   fx_inv;
    logic [FRAC_W:0]   fy_inv;

    assign fx_inv = W_ONE - (FRAC_W+1)'(i_fx);
    assign fy_inv = W_ONE - (FRAC_W+1)'(r_d_fy);

    // Stage D: blend along the row, top and bottom pairs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
        end else if (i_en) begin
            r_d_valid <= i_valid;
            r_e_valid <= r_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d_tail <= i_tail;
            r_d_fy   <= i_fy;
            r_d_b    <= HB_W'(HB_W'(i_g00) * HB_W'(fx_inv) + HB_W'(i_g01) * HB_W'(i_fx));
            r_d_t    <= HB_W'(HB_W'(i_g10) * HB_W'(fx_inv) + HB_W'(i_g11) * HB_W'(i_fx));
        end
    end

    // Stage E: blend between the two rows.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e_tail <= r_d_tail;
            r_e_gq   <= GQ_W'(GQ_W'(r_d_b) * GQ_W'(fy_inv) + GQ_W'(r_d_t) * GQ_W'(r_d_fy));
        end
    end

    assign o_valid = r_e_valid;
    assign o_tail  = r_e_tail;
    assign o_gq    = r_e_gq;
endmodule

// ===== hw/rtl/bgmc_apply.sv =====
// Applies the gain around the black level, rounds half up and saturates.
// Partial products, sum, then the output register. Depends on bgmc_pkg.
module bgmc_apply (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  bgmc_pkg::t_tail                   i_tail,
    input  logic [bgmc_pkg::GQ_W-1:0]         i_gq,
    output logic                              o_valid,
    output logic [bgmc_pkg::PIXEL_BITS-1:0]   o_value
);
    import bgmc_pkg::*;

    localparam logic [RES_W-1:0] PIX_MAX = RES_W'((1 << PIXEL_BITS) - 1);
    localparam logic signed [TOT_W-1:0] HALF = TOT_W'(1) <<< RND_POS;

    logic                     r_f_valid;
    logic                     r_f_pix;
    logic [BLK_W-1:0]         r_f_blk;
    logic signed [PP_W-1:0]   r_f_plo;
    logic signed [PP_W-1:0]   r_f_phi;
    logic                     r_g_valid;
    logic                     r_g_pix;
    logic signed [TOT_W-1:0]  r_g_total;
    logic                     r_out_valid;
    logic [PIXEL_BITS-1:0]    r_out_value;
    logic signed [TOT_W-1:0]  rnd;
    logic [RES_W-1:0]         res;
    logic [PIXEL_BITS-1:0]    n_out_value;

    // Stage F: signed difference times the two halves of the gain.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
            r_g_valid <= 1'b0;
        end else if (i_en) begin
            r_f_valid <= i_valid;
            r_g_valid <= r_f_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f_pix <= (i_tail.cmd == CMD_PIXEL);
            r_f_blk <= i_tail.blk;
            r_f_plo <= i_tail.diff * $signed({1'b0, i_gq[GQ_HALF-1:0]});
            r_f_phi <= i_tail.diff * $signed({1'b0, i_gq[GQ_W-1:GQ_HALF]});
        end
    end

    // Stage G: recombine and add the black level back in Q.36.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_g_pix   <= r_f_pix;
            r_g_total <= (TOT_W'(r_f_phi) <<< GQ_HALF) + TOT_W'(r_f_plo)
                       + $signed({(TOT_W-BLK_W-3*FRAC_W)'(0), r_f_blk, (3*FRAC_W)'(0)});
        end
    end

    // Stage H: round half up, clamp to the pixel range.
    assign rnd = r_g_total + HALF;
    assign res = rnd[TOT_W-1:RND_POS+1];

    always_comb begin
        if (r_g_total <= 0) begin
            n_out_value = '0;
        end else if (res > PIX_MAX) begin
            n_out_value = PIX_MAX[PIXEL_BITS-1:0];
        end else begin
            n_out_value = res[PIXEL_BITS-1:0];
        end
    end

    // Only pixel commands leave a transaction on the output.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_out_valid <= r_g_valid && r_g_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out_value <= n_out_value;
        end
    end

    assign o_valid = r_out_valid;
    assign o_value = r_out_value;

    // A pixel leaving the sum stage shows up at the output.
    a_pix_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && r_g_valid && r_g_pix) |=> r_out_valid)
        else $error("pixel lost at output stage");

    // A write command never produces an output transaction.
    a_wr_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && r_g_valid && !r_g_pix) |=> !r_out_valid)
        else $error("write command produced a result");

    // A non-positive sum clamps to zero.
    a_clamp_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && r_g_valid && r_g_pix && (r_g_total <= 0)) |=> (r_out_value == '0))
        else $error("negative sum not clamped");

    // A stall freezes the product and sum stages.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> ($stable(r_f_valid) && $stable(r_g_valid)))
        else $error("stage moved during stall");
endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the Bayer gain-map correction block.
// Drives pixel and gain-write commands, mirrors the lens-shading arithmetic and
// checks every corrected pixel. Depends on bgmc_pkg, bgmc_ifs and the RTL top.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import bgmc_pkg::*;

    // One command as it appears on the pixel channel.
    typedef struct {
        logic                  command;
        logic [COORD_W-1:0]    pixel_row;
        logic [COORD_W-1:0]    pixel_col;
        logic [PIXEL_BITS-1:0] pixel_value;
        logic [1:0]            cfa_color;
        logic [MAP_W-1:0]      map_select;
        logic [ENTRY_W-1:0]    entry_index;
        logic [GAIN_W-1:0]     gain_value;
    } t_shade_cmd;

    localparam int SETTLE_CYCLES = 16;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bgmc_pix_if pix();
    bgmc_res_if res();
    bgmc_cfg_if cfg();

    bayer_gain_map_correction dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix),
        .o_res   (res),
        .i_cfg   (cfg)
    );

    // Mirror of the block's registers and gain storage.
    logic [GAIN_W-1:0]     gain_mirror [RAM_DEPTH];
    bit                    entry_loaded [RAM_DEPTH];
    logic [BLK_W-1:0]      black_mirror [4];
    logic [STEP_W-1:0]     col_step_mirror;
    logic [STEP_W-1:0]     row_step_mirror;
    logic [GC_W-1:0]       grid_cols_mirror;
    logic [7:0]            phase_map_mirror;

    logic [PIXEL_BITS-1:0] pending_pixels [$];
    int                    mismatch_count = 0;
    int                    items_sent = 0;
    bit                    steady = 1'b0;

    // Clock with an 8 ns period.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Global watchdog.
    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic report_mismatch(input string what, input int exp_v, input int got_v);
        mismatch_count++;
        $display("%0t: %s expected %0d got %0d", $realtime, what, exp_v, got_v);
    endtask

    // Places one coordinate on the grid: lower and upper point and 12-bit weight.
    function automatic void grid_locate(input logic [COORD_W-1:0] coord,
                                        input logic [STEP_W-1:0] step, input int points,
                                        output int lo, output int hi, output int w);
        logic [POS_W-1:0] pos;
        longint           idx;
        pos = POS_W'(coord) * POS_W'(step);
        idx = longint'(pos >> STEP_W);
        if (idx >= points - 1) begin
            lo = points - 1;
            hi = points - 1;
            w  = 0;
        end else begin
            lo = int'(idx);
            hi = int'(idx) + 1;
            w  = int'(pos[STEP_W-1:FRAC_W]);
        end
    endfunction

    // Storage addresses of the four corners and the weights for one pixel.
    function automatic void pixel_corners(input logic [COORD_W-1:0] row,
                                          input logic [COORD_W-1:0] col,
                                          output int addr [4], output int fx, output int fy);
        int gc, rows, phase, mapn, x0, x1, y0, y1;
        gc = int'(grid_cols_mirror);
        if (gc < 2) gc = 2;
        if (gc > GRID_DIM) gc = GRID_DIM;
        rows = MAP_ENTRIES / gc;
        if (rows > GRID_DIM) rows = GRID_DIM;
        phase = {row[0], col[0]};
        mapn = ((phase_map_mirror >> (2 * phase)) & 3) % NUM_MAPS;
        grid_locate(col, col_step_mirror, gc, x0, x1, fx);
        grid_locate(row, row_step_mirror, rows, y0, y1, fy);
        addr[0] = mapn * MAP_ENTRIES + y0 * gc + x0;
        addr[1] = mapn * MAP_ENTRIES + y0 * gc + x1;
        addr[2] = mapn * MAP_ENTRIES + y1 * gc + x0;
        addr[3] = mapn * MAP_ENTRIES + y1 * gc + x1;
    endfunction

    // Bilinear gain, black-level offset, round half up and saturate.
    function automatic logic [PIXEL_BITS-1:0] shade_correct(input t_shade_cmd c);
        int     addr [4];
        int     fx, fy;
        longint top, bot, gq, blk, total, rounded;
        pixel_corners(c.pixel_row, c.pixel_col, addr, fx, fy);
        top = longint'(gain_mirror[addr[0]]) * (4096 - fx)
            + longint'(gain_mirror[addr[1]]) * fx;
        bot = longint'(gain_mirror[addr[2]]) * (4096 - fx)
            + longint'(gain_mirror[addr[3]]) * fx;
        gq = top * (4096 - fy) + bot * fy;
        blk = longint'(black_mirror[c.cfa_color]);
        total = (longint'(c.pixel_value) - blk) * gq + (blk <<< 36);
        if (total <= 0) return '0;
        rounded = (total + (64'sd1 <<< 35)) >>> 36;
        if (rounded > 65535) rounded = 65535;
        return PIXEL_BITS'(rounded);
    endfunction

    // Sends one command, with random idle cycles outside steady stretches.
    task automatic send_cmd(input t_shade_cmd c);
        if (!steady) begin
            while ($urandom_range(99) < 8) begin
                pix.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        pix.valid       <= 1'b1;
        pix.command     <= c.command;
        pix.pixel_row   <= c.pixel_row;
        pix.pixel_col   <= c.pixel_col;
        pix.pixel_value <= c.pixel_value;
        pix.cfa_color   <= c.cfa_color;
        pix.map_select  <= c.map_select;
        pix.entry_index <= c.entry_index;
        pix.gain_value  <= c.gain_value;
        @(posedge i_clk);
        while (!pix.ready) @(posedge i_clk);
        items_sent++;
        if (c.command == CMD_PIXEL) begin
            pending_pixels = {pending_pixels, shade_correct(c)};
        end else begin
            gain_mirror[c.map_select * MAP_ENTRIES + c.entry_index] = c.gain_value;
            entry_loaded[c.map_select * MAP_ENTRIES + c.entry_index] = 1'b1;
        end
    endtask

    function automatic t_shade_cmd random_cmd();
        t_shade_cmd c;
        c.command     = CMD_PIXEL;
        c.pixel_row   = COORD_W'($urandom);
        c.pixel_col   = COORD_W'($urandom);
        c.pixel_value = PIXEL_BITS'($urandom);
        c.cfa_color   = 2'($urandom);
        c.map_select  = MAP_W'($urandom);
        c.entry_index = ENTRY_W'($urandom);
        c.gain_value  = GAIN_W'($urandom);
        return c;
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2, 3: return GAIN_W'($urandom);
            default: return GAIN_W'($urandom_range(8192, 3000));
        endcase
    endfunction

    task automatic load_gain(input int addr, input logic [GAIN_W-1:0] gain);
        t_shade_cmd c;
        c = random_cmd();
        c.command     = CMD_WRITE;
        c.map_select  = MAP_W'(addr / MAP_ENTRIES);
        c.entry_index = ENTRY_W'(addr % MAP_ENTRIES);
        c.gain_value  = gain;
        send_cmd(c);
    endtask

    // Corrects one pixel, first loading any corner the pixel would read unwritten.
    task automatic correct_pixel(input logic [COORD_W-1:0] row, input logic [COORD_W-1:0] col,
                                 input logic [PIXEL_BITS-1:0] val, input logic [1:0] cfa);
        t_shade_cmd c;
        int         addr [4];
        int         fx, fy;
        pixel_corners(row, col, addr, fx, fy);
        for (int k = 0; k < 4; k++) begin
            if (!entry_loaded[addr[k]]) load_gain(addr[k], pick_gain());
        end
        c = random_cmd();
        c.pixel_row   = row;
        c.pixel_col   = col;
        c.pixel_value = val;
        c.cfa_color   = cfa;
        send_cmd(c);
    endtask

    // Register write; the mirror follows at the handshake, then the channel idles before the task returns.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= CFG_DATA_W'(value);
        @(posedge i_clk);
        while (!cfg.ready) @(posedge i_clk);
        cfg.valid <= 1'b0;
        case (idx)
            CFG_BLACK0, CFG_BLACK1, CFG_BLACK2, CFG_BLACK3:
                black_mirror[idx] = BLK_W'(value);
            CFG_COL_STEP:  col_step_mirror  = STEP_W'(value);
            CFG_ROW_STEP:  row_step_mirror  = STEP_W'(value);
            CFG_GRID_COLS: grid_cols_mirror = GC_W'(value);
            CFG_PHASE_MAP: phase_map_mirror = 8'(value);
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Waits until every pixel is back and trailing writes have drained.
    task automatic drain();
        pix.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Result sink: random stalls outside steady stretches.
    always @(posedge i_clk) begin
        if (!i_rst_n || steady) begin
            res.ready <= 1'b1;
        end else begin
            res.ready <= ($urandom_range(99) >= 8);
        end
    end

    // Checks each corrected pixel against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && res.valid && res.ready) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch("unexpected pixel, value", -1, int'(res.corrected_value));
            end else if (res.corrected_value !== pending_pixels[0]) begin
                report_mismatch("corrected_value", int'(pending_pixels[0]),
                                int'(res.corrected_value));
                void'(pending_pixels.pop_front());
            end else begin
                void'(pending_pixels.pop_front());
            end
        end
    end

    // Reset defaults: zero steps put every pixel on the first grid column and row.
    task automatic test_reset_defaults();
        correct_pixel(16'd0, 16'd0, 16'd0, 2'd0);
        correct_pixel(16'd1, 16'd0, 16'hFFFF, 2'd1);
        correct_pixel(16'd0, 16'd1, 16'h8000, 2'd2);
        correct_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 2'd3);
        drain();
    endtask

    // Extreme gains, black levels above the sample and saturation.
    task automatic test_extremes();
        write_reg(CFG_BLACK0, 0);
        write_reg(CFG_BLACK1, 65535);
        write_reg(CFG_BLACK2, 4096);
        write_reg(CFG_BLACK3, 64);
        write_reg(CFG_COL_STEP, 24'h00_4000);
        write_reg(CFG_ROW_STEP, 24'h00_2000);
        write_reg(CFG_GRID_COLS, 8);
        load_gain(0, '1);
        load_gain(1, '0);
        load_gain(8, 16'h1000);
        load_gain(9, 16'h1000);
        correct_pixel(16'd2, 16'd2, 16'hFFFF, 2'd0);
        correct_pixel(16'd2, 16'd2, 16'd0, 2'd1);
        correct_pixel(16'd2, 16'd2, 16'hFFFF, 2'd1);
        correct_pixel(16'd4, 16'd6, 16'd100, 2'd2);
        correct_pixel(16'd4, 16'd6, 16'd5000, 2'd3);
        drain();
    endtask

    // Positions past the last grid point, grid column clamping and phase-to-map selection.
    task automatic test_edges();
        write_reg(CFG_COL_STEP, 24'hFF_FFFF);
        write_reg(CFG_ROW_STEP, 24'hFF_FFFF);
        write_reg(CFG_GRID_COLS, 0);
        write_reg(CFG_PHASE_MAP, 8'hFF);
        correct_pixel(16'hFFFF, 16'hFFFF, 16'h1234, 2'd0);
        correct_pixel(16'd0, 16'd1, 16'h4321, 2'd2);
        drain();
        write_reg(CFG_GRID_COLS, 1);
        write_reg(CFG_PHASE_MAP, 8'h1B);
        correct_pixel(16'd1, 16'd1, 16'hFFFF, 2'd0);
        drain();
        write_reg(CFG_GRID_COLS, 127);
        write_reg(CFG_PHASE_MAP, 8'h00);
        correct_pixel(16'd63, 16'd63, 16'hABCD, 2'd3);
        drain();
        write_reg(CFG_GRID_COLS, 64);
        correct_pixel(16'd3, 16'd2, 16'hFFFF, 2'd2);
        correct_pixel(16'd2, 16'd3, 16'd1, 2'd1);
        drain();
    endtask

    // Random phases: random registers, then pixels mixed with stray gain writes.
    // The first phase runs with no idling on either side.
    task automatic test_random(input int total_items);
        int gc, width, phase_items;
        bit first_phase;
        first_phase = 1'b1;
        while (items_sent < total_items) begin
            gc = ($urandom_range(7) == 0) ? $urandom_range(127) : $urandom_range(64, 2);
            for (int b = 0; b < 4; b++) begin
                write_reg(CFG_BLACK0 + CFG_IDX_W'(b), ($urandom_range(3) == 0) ?
                          $urandom_range(65535) : $urandom_range(1024));
            end
            write_reg(CFG_GRID_COLS, gc);
            if (gc < 2) gc = 2;
            if (gc > GRID_DIM) gc = GRID_DIM;
            width = $urandom_range(65535, 16);
            write_reg(CFG_COL_STEP, ($urandom_range(4) == 0) ? $urandom_range(24'hFF_FFFF) :
                      int'((longint'(gc - 1) << 24) / width));
            width = $urandom_range(65535, 16);
            write_reg(CFG_ROW_STEP, ($urandom_range(4) == 0) ? $urandom_range(24'hFF_FFFF) :
                      int'((longint'(GRID_DIM - 1) << 24) / width));
            write_reg(CFG_PHASE_MAP, $urandom_range(255));
            steady = first_phase || ($urandom_range(3) == 0);
            first_phase = 1'b0;
            phase_items = $urandom_range(220, 80);
            for (int n = 0; n < phase_items && items_sent < total_items; n++) begin
                if ($urandom_range(9) == 0) begin
                    load_gain($urandom_range(RAM_DEPTH - 1), pick_gain());
                end else begin
                    correct_pixel(COORD_W'($urandom), COORD_W'($urandom),
                                  PIXEL_BITS'($urandom), 2'($urandom));
                end
            end
            drain();
            steady = 1'b0;
        end
    endtask

    initial begin
        pix.valid       <= 1'b0;
        pix.command     <= CMD_PIXEL;
        pix.pixel_row   <= '0;
        pix.pixel_col   <= '0;
        pix.pixel_value <= '0;
        pix.cfa_color   <= '0;
        pix.map_select  <= '0;
        pix.entry_index <= '0;
        pix.gain_value  <= '0;
        cfg.valid       <= 1'b0;
        cfg.index       <= CFG_BLACK0;
        cfg.data        <= '0;
        i_rst_n         <= 1'b0;
        for (int a = 0; a < RAM_DEPTH; a++) begin
            gain_mirror[a]  = '0;
            entry_loaded[a] = 1'b0;
        end
        for (int b = 0; b < 4; b++) black_mirror[b] = '0;
        col_step_mirror  = '0;
        row_step_mirror  = '0;
        grid_cols_mirror = GRID_COLS_RST;
        phase_map_mirror = PHASE_MAP_RST;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_extremes();
        test_edges();
        test_random(1350);

        drain();
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
